### hdl/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared constants and types for the CSV cell tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int LINE_MAX   = 1024;
  localparam int POS_W      = $clog2(LINE_MAX + 1);
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE     = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;

  localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'd44;
  localparam logic [CELL_W-1:0] MAX_CELLS_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CELLS = 1'd1;

  typedef struct packed {
    logic              cell_valid;
    logic [CELL_W-1:0] cell_start;
    logic [CELL_W-1:0] cell_end;
    logic [CELL_W-1:0] cell_number;
    logic              row_end;
    logic              overflow;
  } cell_result_t;

endpackage

### hdl/csvt_if.sv
// ----------------------------------------------------------------------------
// csvt_if
// Valid/ready channels for line bytes in and cell results out.
// ----------------------------------------------------------------------------
interface csvt_char_if;
  logic                         valid;
  logic                         ready;
  logic [csvt_pkg::CHAR_W-1:0]  char_byte;
  logic                         line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface csvt_cell_if;
  logic                         valid;
  logic                         ready;
  logic                         cell_valid;
  logic [csvt_pkg::CELL_W-1:0]  cell_start;
  logic [csvt_pkg::CELL_W-1:0]  cell_end;
  logic [csvt_pkg::CELL_W-1:0]  cell_number;
  logic                         row_end;
  logic                         overflow;

  modport source (output valid, output cell_valid, output cell_start, output cell_end,
                  output cell_number, output row_end, output overflow, input ready);
  modport sink   (input valid, input cell_valid, input cell_start, input cell_end,
                  input cell_number, input row_end, input overflow, output ready);
endinterface

### hdl/csv_cell_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_cell_tokenizer
// Splits a text line, one byte per item, into trimmed non-empty cells.
// ----------------------------------------------------------------------------
// Usage:
//   chars : one line byte per item (char_byte), or line_end to close the line.
//   cells : one result per finished cell, and one result with row_end for
//           every line_end (cell_valid 0 when no cell was open).
//   cfg   : cfg_write with cfg_index 0 sets the separator, 1 sets max_cells
//           (0 = no limit). Write only while the block is idle.
// Timing:
//   An item is decoded in the cycle it is accepted; its result, if any, is
//   in the output register in the next cycle. One item per cycle is taken,
//   set by the single state update and the output register, unless stalled.
// Stall:
//   chars.ready drops while a result waits and cells.ready is low; it
//   returns in the cycle the result is taken.
// Reset:
//   rst clears the line state and the output valid flag, and restores
//   separator 44 (comma) and max_cells 0.
// ----------------------------------------------------------------------------
module csv_cell_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  csvt_char_if.sink                         chars,
  csvt_cell_if.source                       cells,
  input  logic                              cfg_write,
  input  logic [csvt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csvt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [csvt_pkg::CHAR_W-1:0] separator;
  logic [csvt_pkg::CELL_W-1:0] max_cells;

  logic [csvt_pkg::POS_W-1:0]  position, position_next;
  logic                        in_quote, in_quote_next;
  logic                        escape_pending, escape_pending_next;
  logic                        cell_open, cell_open_next;
  logic [csvt_pkg::CELL_W-1:0] open_start, open_start_next;
  logic [csvt_pkg::CELL_W-1:0] last_kept, last_kept_next;
  logic [csvt_pkg::CELL_W-1:0] cells_seen, cells_seen_next;
  logic                        limit_hit, limit_hit_next;

  logic                        out_valid;
  csvt_pkg::cell_result_t      out_result, result_next;
  logic                        result_fire;

  logic                        accept;
  logic                        open_ok;
  logic [csvt_pkg::CHAR_W-1:0] c;
  logic [csvt_pkg::CELL_W-1:0] p;

  assign chars.ready = !out_valid || cells.ready;
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.char_byte;
  assign p           = position[csvt_pkg::CELL_W-1:0];
  assign open_ok     = cell_open || (max_cells == '0) || (cells_seen < max_cells);

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= csvt_pkg::SEPARATOR_RESET;
      max_cells <= csvt_pkg::MAX_CELLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        csvt_pkg::REG_SEPARATOR: separator <= cfg_data[csvt_pkg::CHAR_W-1:0];
        csvt_pkg::REG_MAX_CELLS: max_cells <= cfg_data[csvt_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    position_next       = position;
    in_quote_next       = in_quote;
    escape_pending_next = escape_pending;
    cell_open_next      = cell_open;
    open_start_next     = open_start;
    last_kept_next      = last_kept;
    cells_seen_next     = cells_seen;
    limit_hit_next      = limit_hit;
    result_fire         = 1'b0;
    result_next         = '0;

    if (accept) begin
      if (chars.line_end) begin
        result_fire          = 1'b1;
        result_next.row_end  = 1'b1;
        result_next.overflow = limit_hit;
        if (cell_open) begin
          result_next.cell_valid  = 1'b1;
          result_next.cell_start  = open_start;
          result_next.cell_end    = last_kept;
          result_next.cell_number = cells_seen - 1'b1;
        end
        position_next       = '0;
        in_quote_next       = 1'b0;
        escape_pending_next = 1'b0;
        cell_open_next      = 1'b0;
        open_start_next     = '0;
        last_kept_next      = '0;
        cells_seen_next     = '0;
        limit_hit_next      = 1'b0;
      end else if (!limit_hit && (position < csvt_pkg::POS_W'(csvt_pkg::LINE_MAX))) begin
        position_next = position + 1'b1;
        if (escape_pending && (c != csvt_pkg::CHAR_NUL)) begin
          escape_pending_next = 1'b0;
          last_kept_next      = p;
        end else if (c == csvt_pkg::CHAR_BACKSLASH) begin
          if (open_ok) begin
            if (!cell_open) begin
              cell_open_next  = 1'b1;
              open_start_next = p;
              cells_seen_next = cells_seen + 1'b1;
            end
            last_kept_next      = p;
            escape_pending_next = 1'b1;
          end else begin
            limit_hit_next = 1'b1;
          end
        end else if ((c == separator) || (c == csvt_pkg::CHAR_NUL) ||
                     (in_quote && (c == csvt_pkg::CHAR_QUOTE))) begin
          in_quote_next       = 1'b0;
          escape_pending_next = 1'b0;
          if (cell_open) begin
            result_fire             = 1'b1;
            result_next.cell_valid  = 1'b1;
            result_next.cell_start  = open_start;
            result_next.cell_end    = last_kept;
            result_next.cell_number = cells_seen - 1'b1;
            result_next.overflow    = limit_hit;
            cell_open_next          = 1'b0;
          end
        end else if (c == csvt_pkg::CHAR_QUOTE) begin
          in_quote_next = 1'b1;
        end else if ((c == csvt_pkg::CHAR_SPACE) || (c == csvt_pkg::CHAR_TAB)) begin
          // drop blank
        end else if (open_ok) begin
          if (!cell_open) begin
            cell_open_next  = 1'b1;
            open_start_next = p;
            cells_seen_next = cells_seen + 1'b1;
          end
          last_kept_next = p;
        end else begin
          limit_hit_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      in_quote       <= 1'b0;
      escape_pending <= 1'b0;
      cell_open      <= 1'b0;
      open_start     <= '0;
      last_kept      <= '0;
      cells_seen     <= '0;
      limit_hit      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      position       <= position_next;
      in_quote       <= in_quote_next;
      escape_pending <= escape_pending_next;
      cell_open      <= cell_open_next;
      open_start     <= open_start_next;
      last_kept      <= last_kept_next;
      cells_seen     <= cells_seen_next;
      limit_hit      <= limit_hit_next;
      if (result_fire) begin
        out_valid <= 1'b1;
      end else if (cells.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      out_result <= result_next;
    end
  end

  assign cells.valid       = out_valid;
  assign cells.cell_valid  = out_result.cell_valid;
  assign cells.cell_start  = out_result.cell_start;
  assign cells.cell_end    = out_result.cell_end;
  assign cells.cell_number = out_result.cell_number;
  assign cells.row_end     = out_result.row_end;
  assign cells.overflow    = out_result.overflow;

`ifndef SYNTHESIS
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result appeared without an accepted item");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.line_end) |=> (position == '0) && !cell_open && (cells_seen == '0)
      && !limit_hit)
    else $error("line state not cleared after line end");

  a_cell_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.cell_valid) |-> (out_result.cell_end >= out_result.cell_start))
    else $error("cell end before cell start");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cells.ready) |-> !chars.ready)
    else $error("item taken while result stalled");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds text lines byte by byte into the CSV cell tokenizer with random
// flow control on both channels. Each cell result is checked field by field
// against a behavioral splitter model that covers trimming, quoting, escapes,
// empty cells, the cell limit and over-long lines. It runs under several
// separator and limit settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int GAP_MAX       = 19;
  localparam int SETTLE_CYCLES = 3;
  localparam int HANG_LIMIT    = 2000;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write;
  logic [csvt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [csvt_pkg::CFG_DATA_W-1:0] cfg_data;

  csvt_char_if chars_if ();
  csvt_cell_if cells_if ();

  csv_cell_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .cells     (cells_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [csvt_pkg::CHAR_W-1:0] sep_char;
  logic [csvt_pkg::CELL_W-1:0] cell_limit;
  int unsigned                 line_pos;
  bit                          quoting;
  bit                          escaping;
  bit                          cell_is_open;
  bit                          over_limit;
  logic [csvt_pkg::CELL_W-1:0] start_pos;
  logic [csvt_pkg::CELL_W-1:0] last_pos;
  int unsigned                 cell_count;

  csvt_pkg::cell_result_t expected_cells[$];
  csvt_pkg::cell_result_t seen_cell;
  csvt_pkg::cell_result_t due_cell;
  int           mismatches   = 0;
  int           src_gap_max  = 0;
  int           sink_gap_max = 0;
  int           idle_cycles  = 0;
  int unsigned  items_sent   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_line();
    line_pos     = 0;
    quoting      = 1'b0;
    escaping     = 1'b0;
    cell_is_open = 1'b0;
    start_pos    = '0;
    last_pos     = '0;
    cell_count   = 0;
    over_limit   = 1'b0;
  endfunction

  function automatic csvt_pkg::cell_result_t make_result(bit with_cell, bit row);
    csvt_pkg::cell_result_t r;
    r = '0;
    if (with_cell) begin
      r.cell_valid  = 1'b1;
      r.cell_start  = start_pos;
      r.cell_end    = last_pos;
      r.cell_number = csvt_pkg::CELL_W'(cell_count - 1);
    end
    r.row_end  = row;
    r.overflow = over_limit;
    return r;
  endfunction

  function automatic void queue_expected(csvt_pkg::cell_result_t r);
    expected_cells.insert(expected_cells.size(), r);
  endfunction

  function automatic bit keep_pos(int unsigned p);
    if (!cell_is_open) begin
      if (cell_limit != 0 && cell_count >= cell_limit) begin
        over_limit = 1'b1;
        return 1'b0;
      end
      cell_is_open = 1'b1;
      start_pos    = csvt_pkg::CELL_W'(p);
      cell_count++;
    end
    last_pos = csvt_pkg::CELL_W'(p);
    return 1'b1;
  endfunction

  function automatic void tokenize(logic [csvt_pkg::CHAR_W-1:0] ch, logic le);
    int unsigned p;
    if (le) begin
      queue_expected(make_result(cell_is_open, 1'b1));
      clear_line();
      return;
    end
    if (over_limit || line_pos >= csvt_pkg::LINE_MAX) return;
    p = line_pos;
    line_pos++;
    if (escaping && ch != csvt_pkg::CHAR_NUL) begin
      escaping = 1'b0;
      last_pos = csvt_pkg::CELL_W'(p);
    end else if (ch == csvt_pkg::CHAR_BACKSLASH) begin
      if (keep_pos(p)) escaping = 1'b1;
    end else if (ch == sep_char || ch == csvt_pkg::CHAR_NUL ||
                 (quoting && ch == csvt_pkg::CHAR_QUOTE)) begin
      quoting  = 1'b0;
      escaping = 1'b0;
      if (cell_is_open) begin
        queue_expected(make_result(1'b1, 1'b0));
        cell_is_open = 1'b0;
      end
    end else if (ch == csvt_pkg::CHAR_QUOTE) begin
      quoting = 1'b1;
    end else if (ch != csvt_pkg::CHAR_SPACE && ch != csvt_pkg::CHAR_TAB) begin
      void'(keep_pos(p));
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic [csvt_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(19, 0))
      0, 1, 2, 3, 4, 5, 6, 7: return csvt_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21));
      8, 9:                   return csvt_pkg::CHAR_SPACE;
      10:                     return csvt_pkg::CHAR_TAB;
      11, 12:                 return sep_char;
      13:                     return csvt_pkg::CHAR_QUOTE;
      14:                     return csvt_pkg::CHAR_BACKSLASH;
      15:                     return csvt_pkg::CHAR_NUL;
      default:                return csvt_pkg::CHAR_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [csvt_pkg::CHAR_W-1:0] pick_separator();
    case ($urandom_range(7, 0))
      0:       return csvt_pkg::CHAR_TAB;
      1:       return csvt_pkg::CHAR_SPACE;
      2:       return csvt_pkg::CHAR_QUOTE;
      3:       return csvt_pkg::CHAR_BACKSLASH;
      4:       return csvt_pkg::CHAR_NUL;
      5:       return 8'hFF;
      6:       return csvt_pkg::CHAR_W'($urandom_range(255, 0));
      default: return csvt_pkg::SEPARATOR_RESET;
    endcase
  endfunction

  function automatic logic [csvt_pkg::CELL_W-1:0] pick_limit();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return csvt_pkg::CELL_W'(1);
      2:       return csvt_pkg::CELL_W'(2);
      3:       return csvt_pkg::CELL_W'(3);
      4:       return '1;
      default: return csvt_pkg::CELL_W'($urandom_range(1023, 0));
    endcase
  endfunction

  task automatic send_item(logic [csvt_pkg::CHAR_W-1:0] ch, logic le);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_byte <= ch;
    chars_if.line_end  <= le;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    tokenize(ch, le);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic end_line();
    send_item(csvt_pkg::CHAR_W'($urandom_range(255, 0)), 1'b1);
  endtask

  task automatic wait_results_drained();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [csvt_pkg::CHAR_W-1:0] sep,
                              logic [csvt_pkg::CELL_W-1:0] limit);
    wait_results_drained();
    cfg_write <= 1'b1;
    cfg_index <= csvt_pkg::REG_SEPARATOR;
    cfg_data  <= csvt_pkg::CFG_DATA_W'(sep);
    @(posedge clk);
    cfg_index <= csvt_pkg::REG_MAX_CELLS;
    cfg_data  <= csvt_pkg::CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_write  <= 1'b0;
    sep_char   = sep;
    cell_limit = limit;
  endtask

  task automatic test_reset_settings();
    src_gap_max  = GAP_MAX;
    sink_gap_max = GAP_MAX;
    // quoted cell with an escaped comma, empty cells, NUL, mid-cell quote
    send_text(" \"a \\,b\",");
    send_item(csvt_pkg::CHAR_NUL, 1'b0);
    send_text("x\"y\"\t");
    send_item(8'hFF, 1'b0);
    send_text("\\");
    end_line();
    end_line();
  endtask

  task automatic test_cell_limit();
    write_config(csvt_pkg::CHAR_TAB, csvt_pkg::CELL_W'(1));
    send_text("\\");
    send_item(csvt_pkg::CHAR_NUL, 1'b0);
    send_text("a\t");
    end_line();
  endtask

  task automatic test_long_lines();
    write_config(8'hFF, '1);
    src_gap_max  = 0;
    sink_gap_max = GAP_MAX;
    repeat (csvt_pkg::LINE_MAX - 4) send_item(pick_char(), 1'b0);
    repeat (8) send_item("b", 1'b0);
    end_line();
  endtask

  task automatic send_cell_line();
    int  n_cells;
    bit  quoted;
    n_cells = $urandom_range(6, 1);
    for (int k = 0; k < n_cells; k++) begin
      quoted = $urandom_range(2, 0) == 0;
      repeat ($urandom_range(2, 0))
        send_item($urandom_range(1, 0) ? csvt_pkg::CHAR_SPACE : csvt_pkg::CHAR_TAB, 1'b0);
      if (quoted) send_item(csvt_pkg::CHAR_QUOTE, 1'b0);
      repeat ($urandom_range(5, 0)) begin
        case ($urandom_range(7, 0))
          0: begin
            send_item(csvt_pkg::CHAR_BACKSLASH, 1'b0);
            send_item(csvt_pkg::CHAR_W'($urandom_range(255, 0)), 1'b0);
          end
          1: send_item(csvt_pkg::CHAR_SPACE, 1'b0);
          default: send_item(csvt_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21)), 1'b0);
        endcase
      end
      if (quoted) send_item(csvt_pkg::CHAR_QUOTE, 1'b0);
      repeat ($urandom_range(2, 0))
        send_item($urandom_range(1, 0) ? csvt_pkg::CHAR_SPACE : csvt_pkg::CHAR_TAB, 1'b0);
      if (k != n_cells - 1) send_item(sep_char, 1'b0);
    end
    end_line();
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(30, 0)) send_item(pick_char(), 1'b0);
    end_line();
  endtask

  task automatic test_random_lines();
    int          phase;
    int unsigned phase_end;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) write_config(csvt_pkg::CHAR_NUL, '0);
      else write_config(pick_separator(), pick_limit());
      src_gap_max  = (phase % 2 == 1) ? GAP_MAX : 0;
      sink_gap_max = (phase % 4 >= 2) ? GAP_MAX : 0;
      phase_end = items_sent + 40;
      while (items_sent < phase_end) begin
        if ($urandom_range(3, 0) != 0) send_cell_line();
        else send_noise_line();
        if ($urandom_range(9, 0) == 0) wait_results_drained();
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    cells_if.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = $urandom_range(sink_gap_max, 0);
      if (gap != 0) begin
        cells_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cells_if.ready <= 1'b1;
      @(posedge clk);
      while (!cells_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && cells_if.valid && cells_if.ready) begin
      seen_cell.cell_valid  = cells_if.cell_valid;
      seen_cell.cell_start  = cells_if.cell_start;
      seen_cell.cell_end    = cells_if.cell_end;
      seen_cell.cell_number = cells_if.cell_number;
      seen_cell.row_end     = cells_if.row_end;
      seen_cell.overflow    = cells_if.overflow;
      if (expected_cells.size() == 0) begin
        mismatches++;
        $display("%0t: cell result expected none, actual %h", $time, seen_cell);
      end else begin
        due_cell = expected_cells.pop_front();
        check_field("cell_valid", due_cell.cell_valid, seen_cell.cell_valid);
        check_field("cell_start", due_cell.cell_start, seen_cell.cell_start);
        check_field("cell_end", due_cell.cell_end, seen_cell.cell_end);
        check_field("cell_number", due_cell.cell_number, seen_cell.cell_number);
        check_field("row_end", due_cell.row_end, seen_cell.row_end);
        check_field("overflow", due_cell.overflow, seen_cell.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((chars_if.valid && chars_if.ready) || (cells_if.valid && cells_if.ready) ||
        cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    chars_if.valid     <= 1'b0;
    chars_if.char_byte <= '0;
    chars_if.line_end  <= 1'b0;
    cfg_write          <= 1'b0;
    cfg_index          <= csvt_pkg::REG_SEPARATOR;
    cfg_data           <= '0;
    sep_char   = csvt_pkg::SEPARATOR_RESET;
    cell_limit = csvt_pkg::MAX_CELLS_RESET;
    clear_line();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_cell_limit();
    test_long_lines();
    test_random_lines();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
